[rtl/rmsn_pkg.sv]
`timescale 1ns / 1ps

package rmsn_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] sample;
        logic [31:0] gain;
        logic        last;
    } rmsn_in_t;

    typedef struct packed {
        logic [31:0] normalized;
        logic        end_of_vector;
    } rmsn_out_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_APPLY = 1'b1;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_DONE,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_INV_INIT,
        CMD_INV_DONE,
        CMD_APPLY_READ,
        CMD_APPLY_MUL1,
        CMD_APPLY_MUL2
    } rmsn_cmd_t;

    typedef struct packed {
        logic closed;
        logic apply_ok;
        logic rad_ok;
        logic rms_nz;
    } rmsn_status_t;

endpackage

[rtl/rmsn_datapath.sv]
`timescale 1ns / 1ps

module rmsn_datapath
    import rmsn_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM   = 4096,
    parameter int AW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int CW        = $clog2(MAX_DIM + 1)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  rmsn_cmd_t    cmd,
    input  rmsn_in_t     item,
    input  logic [30:0]  epsilon,
    output rmsn_status_t status,
    output rmsn_out_t    result,
    output logic         result_strobe
);

    logic [31:0]   store_mem [MAX_DIM];
    logic [63:0]   sum_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          closed_reg;
    logic [31:0]   inv_reg;
    logic [31:0]   rd_reg;
    logic [31:0]   gain_reg;
    logic [31:0]   mul_reg;
    logic          eov_reg;
    logic          neg_reg;
    logic [63:0]   num_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   quo_reg;
    logic [63:0]   dvs_reg;
    logic [31:0]   rad_reg;
    logic [63:0]   res_reg;
    logic [63:0]   bit_reg;
    logic [63:0]   sq_reg;
    logic [31:0]   res_out_reg;
    logic          res_strobe_reg;

    logic [63:0] sq_full;
    logic [63:0] sq_shift;
    logic [63:0] rem_sh;
    logic [63:0] sq_trial;
    logic [63:0] m1_full;
    logic [63:0] m2_full;
    logic [31:0] mean_w;
    logic        fresh;
    logic [CW-1:0] cnt_eff;

    assign fresh   = closed_reg;
    assign cnt_eff = fresh ? '0 : count_reg;

    // Square of the incoming sample in fixed point.
    assign sq_full  = $signed(item.sample) * $signed(item.sample);
    assign sq_shift = 64'($signed(sq_full) >>> FRAC_BITS);

    // Restoring divider step and square root trial value.
    assign rem_sh   = {rem_reg[62:0], num_reg[63]};
    assign sq_trial = res_reg + bit_reg;

    assign m1_full = $signed(rd_reg) * $signed(inv_reg);
    assign m2_full = $signed(mul_reg) * $signed(gain_reg);

    assign mean_w = neg_reg ? 32'(64'd0 - quo_reg) : quo_reg[31:0];

    assign status.closed   = closed_reg;
    assign status.apply_ok = closed_reg && (idx_reg < count_reg);
    assign status.rad_ok   = (rad_reg != 32'd0) && !rad_reg[31];
    assign status.rms_nz   = (res_reg[31:0] != 32'd0);

    // Sample store, one write or one read a cycle.
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD && cnt_eff < CW'(MAX_DIM))
        begin
            store_mem[cnt_eff[AW-1:0]] <= item.sample;
        end
        if (cmd == CMD_APPLY_READ)
        begin
            rd_reg <= store_mem[idx_reg[AW-1:0]];
        end
    end

    // Control state of the vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            closed_reg     <= 1'b0;
            inv_reg        <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            res_strobe_reg <= 1'b0;
            unique case (cmd)
                CMD_LOAD:
                begin
                    if (fresh)
                    begin
                        idx_reg    <= '0;
                        closed_reg <= 1'b0;
                    end
                    if (cnt_eff < CW'(MAX_DIM))
                    begin
                        sum_reg   <= (fresh ? 64'd0 : sum_reg)
                                     + {{32{sq_shift[31]}}, sq_shift[31:0]};
                        count_reg <= cnt_eff + 1'b1;
                    end
                    else
                    begin
                        sum_reg   <= fresh ? 64'd0 : sum_reg;
                        count_reg <= cnt_eff;
                    end
                end
                CMD_INV_INIT:
                begin
                    closed_reg <= 1'b1;
                    inv_reg    <= '0;
                end
                CMD_INV_DONE:
                begin
                    closed_reg <= 1'b1;
                    inv_reg    <= quo_reg[31:0];
                end
                CMD_APPLY_MUL2:
                begin
                    idx_reg        <= idx_reg + 1'b1;
                    res_strobe_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Divider, square root and apply working registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_DIV_INIT:
            begin
                neg_reg <= sum_reg[63];
                num_reg <= sum_reg[63] ? 64'd0 - sum_reg : sum_reg;
                dvs_reg <= 64'(count_reg);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                num_reg <= {num_reg[62:0], 1'b0};
                if (rem_sh >= dvs_reg)
                begin
                    rem_reg <= rem_sh - dvs_reg;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            CMD_DIV_DONE:
            begin
                rad_reg <= (count_reg == '0 ? 32'd0 : mean_w) + {1'b0, epsilon};
            end
            CMD_SQRT_INIT:
            begin
                sq_reg  <= 64'(rad_reg) << FRAC_BITS;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            CMD_SQRT_STEP:
            begin
                if (sq_reg >= sq_trial)
                begin
                    sq_reg  <= sq_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            CMD_INV_INIT:
            begin
                num_reg <= 64'd1 << (2 * FRAC_BITS);
                dvs_reg <= {32'd0, res_reg[31:0]};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            CMD_APPLY_READ:
            begin
                gain_reg <= item.gain;
                eov_reg  <= (idx_reg + 1'b1 == count_reg);
            end
            CMD_APPLY_MUL1:
            begin
                mul_reg <= m1_full[FRAC_BITS +: 32];
            end
            CMD_APPLY_MUL2:
            begin
                res_out_reg <= m2_full[FRAC_BITS +: 32];
            end
            default:
            begin
            end
        endcase
    end

    assign result.normalized    = res_out_reg;
    assign result.end_of_vector = eov_reg;
    assign result_strobe        = res_strobe_reg;

endmodule

[rtl/rmsn_control.sv]
`timescale 1ns / 1ps

module rmsn_control
    import rmsn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  rmsn_in_t     item,
    input  rmsn_status_t status,
    output rmsn_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_DONE,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_INV_INIT,
        ST_INV,
        ST_INV_DONE,
        ST_MUL1,
        ST_MUL2
    } state_t;

    state_t     state_reg;
    logic [5:0] step_reg;

    assign busy = (state_reg != ST_IDLE);

    // Command decode from the current state.
    always_comb
    begin
        cmd = CMD_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.operation == OP_LOAD)
                    begin
                        cmd = CMD_LOAD;
                    end
                    else if (status.apply_ok)
                    begin
                        cmd = CMD_APPLY_READ;
                    end
                end
            end
            ST_DIV_INIT:  cmd = CMD_DIV_INIT;
            ST_DIV:       cmd = CMD_DIV_STEP;
            ST_DIV_DONE:  cmd = CMD_DIV_DONE;
            ST_SQRT_INIT: cmd = status.rad_ok ? CMD_SQRT_INIT : CMD_INV_INIT;
            ST_SQRT:      cmd = CMD_SQRT_STEP;
            ST_INV_INIT:  cmd = status.rms_nz ? CMD_DIV_INIT : CMD_INV_INIT;
            ST_INV:       cmd = CMD_DIV_STEP;
            ST_INV_DONE:  cmd = CMD_INV_DONE;
            ST_MUL1:      cmd = CMD_APPLY_MUL1;
            ST_MUL2:      cmd = CMD_APPLY_MUL2;
            default:      cmd = CMD_NONE;
        endcase
        // The inverse divide reloads its own operands.
        if (state_reg == ST_INV_INIT && status.rms_nz)
        begin
            cmd = CMD_INV_INIT;
        end
    end

    // Sequencer; the inverse divide reuses the divider steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (item.operation == OP_LOAD)
                        begin
                            if (item.last)
                            begin
                                state_reg <= ST_DIV_INIT;
                            end
                        end
                        else if (status.apply_ok)
                        begin
                            state_reg <= ST_MUL1;
                        end
                    end
                end
                ST_DIV_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd63)
                    begin
                        state_reg <= ST_DIV_DONE;
                    end
                end
                ST_DIV_DONE:  state_reg <= ST_SQRT_INIT;
                ST_SQRT_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= status.rad_ok ? ST_SQRT : ST_IDLE;
                end
                ST_SQRT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd31)
                    begin
                        state_reg <= ST_INV_INIT;
                    end
                end
                ST_INV_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= status.rms_nz ? ST_INV : ST_IDLE;
                end
                ST_INV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd63)
                    begin
                        state_reg <= ST_INV_DONE;
                    end
                end
                ST_INV_DONE:  state_reg <= ST_IDLE;
                ST_MUL1:      state_reg <= ST_MUL2;
                ST_MUL2:      state_reg <= ST_IDLE;
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/rms_normalization.sv]
`timescale 1ns / 1ps
// Load beats give no result; a load not marked last leaves busy low.
// A load marked last keeps busy high through 64 divider steps for the mean, 32 root
// steps and 64 divider steps for the inverse, or less on a zero or negative radicand
// or a zero root. An apply beat holds busy through a multiply by the inverse and one
// by the gain, which registers the result; the receiver cannot stall it.
// Asynchronous active-low reset clears control state; epsilon resets to 1.
module rms_normalization
    import rmsn_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM   = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rmsn_in_t    in_item,
    output rmsn_out_t   out_item,
    output logic        out_strobe,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    rmsn_cmd_t    cmd;
    rmsn_status_t status;
    logic [30:0]  epsilon_reg;
    logic         busy_int;

    assign busy      = busy_int;
    assign cfg_ready = 1'b1;

    // Epsilon register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= 31'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            epsilon_reg <= cfg_data;
        end
    end

    rmsn_control u_control (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start && !busy_int),
        .item   (in_item),
        .status (status),
        .cmd    (cmd),
        .busy   (busy_int)
    );

    rmsn_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (in_item),
        .epsilon       (epsilon_reg),
        .status        (status),
        .result        (out_item),
        .result_strobe (out_strobe)
    );

endmodule

[rtl/rmsn_checker.sv]
`timescale 1ns / 1ps

module rmsn_checker
    import rmsn_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input rmsn_in_t in_item,
    input logic     out_strobe
);

    // A result strobe is always preceded by a busy cycle.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // Strobes never come in adjacent cycles.
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_strobe |=> !out_strobe)
        else $error("back-to-back result strobes");

    // A plain load that is not last leaves the block idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.operation == OP_LOAD && !in_item.last) |=> !busy)
        else $error("busy after a plain load");

    // A load never produces a result strobe.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.operation == OP_LOAD) |-> ##2 !out_strobe)
        else $error("result after a load");

endmodule

bind rms_normalization rmsn_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe)
);

[tb/tb_rms_normalization.sv]
`timescale 1ns / 1ps

module tb_rms_normalization;
    import rmsn_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 4096;
    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rmsn_in_t    in_item;
    rmsn_out_t   out_item;
    logic        out_strobe;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;

    rms_normalization #(
        .FRAC_BITS(FRAC_BITS),
        .MAX_DIM  (MAX_DIM)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_strobe(out_strobe),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predictor state, mirroring the block.
    logic [30:0] pr_epsilon;
    logic [63:0] pr_square_sum;
    int unsigned pr_count;
    logic [31:0] pr_store [MAX_DIM];
    logic [31:0] pr_inverse;
    int unsigned pr_apply_idx;
    logic        pr_closed;

    rmsn_in_t  pending_beats[$];
    rmsn_out_t expected_results[$];
    int        mismatch_count;
    int        result_count;
    int        vector_count;
    bit        quiet_phase;
    int        send_gap;

    // Signed fixed-point multiply, truncated to 32 bits.
    function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] prod;
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return 32'(prod >>> FRAC_BITS);
    endfunction

    function automatic logic [63:0] bit_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] trial;
        root = '0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            trial = root + probe;
            if (n >= trial)
            begin
                n = n - trial;
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Mean square, root and inverse at the close of a vector.
    task automatic close_vector();
        logic [31:0] mean;
        logic [31:0] radicand;
        logic [63:0] mag;
        logic [63:0] quot;
        logic [63:0] root;
        mean = '0;
        if (pr_count != 0)
        begin
            mag = pr_square_sum[63] ? (64'd0 - pr_square_sum) : pr_square_sum;
            quot = mag / 64'(pr_count);
            mean = 32'(pr_square_sum[63] ? (64'd0 - quot) : quot);
        end
        radicand = mean + {1'b0, pr_epsilon};
        if (radicand == 0 || radicand[31])
            pr_inverse = '0;
        else
        begin
            root = {32'd0, 32'(bit_sqrt({32'd0, radicand} << FRAC_BITS))};
            pr_inverse = (root == 0) ? '0 : 32'((64'd1 << (2 * FRAC_BITS)) / root);
        end
        pr_closed = 1'b1;
    endtask

    // Predict the result, if any, of one accepted beat.
    task automatic predict_beat(rmsn_in_t beat);
        rmsn_out_t res;
        logic [31:0] sq;
        if (beat.operation == OP_LOAD)
        begin
            if (pr_closed)
            begin
                pr_square_sum = '0;
                pr_count = 0;
                pr_apply_idx = 0;
                pr_closed = 1'b0;
            end
            if (pr_count < MAX_DIM)
            begin
                pr_store[pr_count] = beat.sample;
                sq = fx_mul(beat.sample, beat.sample);
                pr_square_sum = pr_square_sum + {{32{sq[31]}}, sq};
                pr_count++;
            end
            if (beat.last)
                close_vector();
        end
        else if (pr_closed && pr_apply_idx < pr_count)
        begin
            res.normalized = fx_mul(fx_mul(pr_store[pr_apply_idx], pr_inverse),
                                    beat.gain);
            res.end_of_vector = (pr_apply_idx + 1 == pr_count);
            pr_apply_idx++;
            expected_results.push_back(res);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: one beat per start, with random idle bursts outside the quiet phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            in_item <= '0;
            send_gap <= 0;
        end
        else if (start && !busy)
        begin
            predict_beat(in_item);
            if (pending_beats.size() != 0 && (quiet_phase || $urandom_range(0, 9) != 0))
            begin
                in_item <= pending_beats.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                send_gap <= quiet_phase ? 0 : $urandom_range(1, 19);
            end
        end
        else if (!start)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_beats.size() != 0)
            begin
                in_item <= pending_beats.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_strobe)
        begin
            result_count++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", out_item.normalized, 32'd0);
            else
            begin
                if (out_item.normalized !== expected_results[0].normalized)
                    report_mismatch("normalized", out_item.normalized,
                                    expected_results[0].normalized);
                if (out_item.end_of_vector !== expected_results[0].end_of_vector)
                    report_mismatch("end_of_vector", 32'(out_item.end_of_vector),
                                    32'(expected_results[0].end_of_vector));
                void'(expected_results.pop_front());
            end
        end
    end

    function automatic rmsn_in_t make_beat(logic op, logic [31:0] smp, logic [31:0] gn,
                                           logic lst);
        rmsn_in_t b;
        b.operation = op;
        b.sample = smp;
        b.gain = gn;
        b.last = lst;
        return b;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | ($urandom() & 32'h1);
            2: return 32'h7FFF_FFFF ^ ($urandom() & 32'h1);
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Queue one vector: loads then applies, with occasional stray beats.
    task automatic queue_vector(int dim, int applies);
        for (int k = 0; k < dim; k++)
        begin
            if ($urandom_range(0, 30) == 0)
                pending_beats.push_back(make_beat(OP_APPLY, $urandom(), $urandom(), 1'b0));
            pending_beats.push_back(make_beat(OP_LOAD, rand_sample(), $urandom(),
                                              k == dim - 1));
        end
        for (int k = 0; k < applies; k++)
            pending_beats.push_back(make_beat(OP_APPLY, $urandom(),
                $urandom_range(0, 3) == 0 ? $urandom() : 32'h0001_0000, 1'($urandom())));
        vector_count++;
    endtask

    task automatic write_epsilon(logic [30:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pr_epsilon = value;
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || start || busy || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    logic [30:0] eps_settings [5] = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'h0000_4000,
                                      31'h4000_0000};

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        result_count = 0;
        vector_count = 0;
        quiet_phase = 1'b0;
        pr_epsilon = 31'd1;
        pr_square_sum = '0;
        pr_count = 0;
        pr_inverse = '0;
        pr_apply_idx = 0;
        pr_closed = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: apply before any close, field extremes, extra applies.
        pending_beats.push_back(make_beat(OP_APPLY, 32'd0, 32'hFFFF_FFFF, 1'b1));
        pending_beats.push_back(make_beat(OP_LOAD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
        pending_beats.push_back(make_beat(OP_LOAD, 32'h7FFF_FFFF, 32'd0, 1'b0));
        pending_beats.push_back(make_beat(OP_LOAD, 32'h0000_0000, 32'd0, 1'b0));
        pending_beats.push_back(make_beat(OP_LOAD, 32'hFFFF_FFFF, 32'd0, 1'b1));
        for (int k = 0; k < 5; k++)
            pending_beats.push_back(make_beat(OP_APPLY, 32'hFFFF_FFFF,
                k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b1));
        // Small samples give a zero mean: radicand is epsilon alone.
        pending_beats.push_back(make_beat(OP_LOAD, 32'h0000_0001, 32'd0, 1'b1));
        pending_beats.push_back(make_beat(OP_APPLY, 32'd0, 32'h0001_0000, 1'b0));
        // Load after close with stray apply in the middle of a vector.
        pending_beats.push_back(make_beat(OP_LOAD, 32'h0001_0000, 32'd0, 1'b0));
        pending_beats.push_back(make_beat(OP_APPLY, 32'd0, 32'h0001_0000, 1'b0));
        pending_beats.push_back(make_beat(OP_LOAD, 32'hFFFF_0000, 32'd0, 1'b1));
        pending_beats.push_back(make_beat(OP_APPLY, 32'd0, 32'h0001_0000, 1'b0));
        wait_idle();

        // Random vectors under four table epsilon settings, extremes included, and one random one.
        for (int e = 0; e < 5; e++)
        begin
            write_epsilon(e == 4 ? 31'($urandom()) : eps_settings[e]);
            for (int v = 0; v < 22; v++)
                queue_vector($urandom_range(0, 7) == 0 ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 8),
                             $urandom_range(0, 10));
            wait_idle();
        end

        // Final stretch with no idling.
        quiet_phase = 1'b1;
        for (int v = 0; v < 10; v++)
            queue_vector($urandom_range(1, 6), $urandom_range(1, 8));
        wait_idle();

        $display("Covered %0d vectors and %0d results over five epsilon settings.",
                 vector_count, result_count);
        if (mismatch_count == 0)
            $display("rms_normalization: match");
        else
            $display("rms_normalization: mismatch");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #4000000;
        $display("rms_normalization: mismatch");
        $finish;
    end

endmodule
